/* design/cfp_pkg.sv */
// ----------------------------------------------------------------------------
// cfp_pkg: shared constants, types and float helpers for clamped_float_power
// Single-precision multiply split into a mantissa product step and a
// normalize/round step, plus an IEEE greater-than compare.
// ----------------------------------------------------------------------------
package cfp_pkg;

    localparam logic [31:0] ONE_BITS    = 32'h3F80_0000;
    localparam logic [31:0] QNAN_BITS   = 32'h7FC0_0000;
    localparam logic [31:0] LIMIT_RESET = 32'h4085_C28F;
    localparam logic [31:0] PINF_BITS   = 32'h7F80_0000;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_NORM = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    // unpacked operand: significand with hidden bit, unbiased-ish exponent
    typedef struct packed {
        logic        sgn;
        logic [9:0]  exp;   // signed, biased-127 removed, adjusted for subnormals
        logic [23:0] man;   // normalized so that man[23] set (unless zero)
        logic        zero;
        logic        inf;
        logic        nan;
    } t_unp;

    // product after the multiplier stage
    typedef struct packed {
        logic        sgn;
        logic [9:0]  exp;
        logic [47:0] prod;
        logic        zero;
        logic        inf;
        logic        nan;
    } t_prod;

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        n = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) n = 5'(23 - i);
        end
        return n;
    endfunction

    function automatic t_unp unpack(input logic [31:0] b);
        t_unp       u;
        logic [4:0] lz;
        u.sgn  = b[31];
        u.nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        u.inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        u.zero = (b[30:0] == 31'd0);
        lz     = lzc24({1'b0, b[22:0]});
        if (b[30:23] == 8'd0) begin
            u.man = 24'({1'b0, b[22:0]} << lz);
            u.exp = 10'(-126) - 10'(lz);
        end else begin
            u.man = {1'b1, b[22:0]};
            u.exp = 10'({2'b00, b[30:23]}) - 10'd127;
        end
        return u;
    endfunction

    // Normalize, round to nearest even, and pack a product.
    function automatic logic [31:0] round_pack(input t_prod p);
        logic              sgn;
        logic signed [10:0] e;
        logic [47:0]       m;
        logic [49:0]       w;
        logic [5:0]        sh;
        logic [23:0]       kept;
        logic              g, st;
        logic [24:0]       r;
        logic [31:0]       res;
        sgn = p.sgn;
        m   = p.prod;
        // significands in [1,2) so product in [1,4); bit 47 or 46 leads
        if (m[47]) begin
            e = 11'(signed'(p.exp)) + 11'sd1;
        end else begin
            e = 11'(signed'(p.exp));
            m = m << 1;
        end
        // m[47] is the hidden bit, value = m/2^47 * 2^e
        w  = {m, 2'b00};
        sh = 6'd0;
        if (e < -11'sd126) begin
            if ((-11'sd126 - e) > 11'sd26) sh = 6'd26;
            else sh = 6'(-11'sd126 - e);
            e = -11'sd126;
        end
        // sticky shift right by sh
        st = 1'b0;
        for (int i = 0; i < 50; i++) begin
            if (i < int'(sh) && w[i]) st = 1'b1;
        end
        w    = w >> sh;
        kept = w[49:26];
        g    = w[25];
        st   = st | (w[24:0] != 25'd0);
        r    = {1'b0, kept} + 25'(g & (st | kept[0]));
        if (r[24]) begin
            r = r >> 1;
            e = e + 11'sd1;
        end
        if (e > 11'sd127) begin
            res = {sgn, 31'h7F80_0000};
        end else if (!r[23]) begin
            res = {sgn, 8'd0, r[22:0]};
        end else begin
            res = {sgn, 8'(e + 11'sd127), r[22:0]};
        end
        if (p.nan || (p.inf && p.zero)) res = QNAN_BITS;
        else if (p.inf) res = {sgn, 31'h7F80_0000};
        else if (p.zero) res = {sgn, 31'd0};
        return res;
    endfunction

    // IEEE a > b; false if either is NaN
    function automatic logic fgt(input logic [31:0] a, input logic [31:0] b);
        logic an, bn, az;
        an = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        bn = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        az = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
        if (an || bn || az) return 1'b0;
        if (a[31] != b[31]) return b[31];
        if (!a[31]) return a[30:0] > b[30:0];
        return a[30:0] < b[30:0];
    endfunction

endpackage

/* design/clamped_float_power.sv */
// ----------------------------------------------------------------------------
// clamped_float_power: saturating float32 power by square-and-multiply
// One shared float multiplier (product state, then round state) walks the
// exponent bits LSB first under a one-hot sequencer.
// ----------------------------------------------------------------------------
// Flow: a non-positive exponent goes straight from idle to done; otherwise the
//   float multiplies run (one squaring per exponent bit below the top set bit,
//   one multiply per set bit), each a product state then a round state.
// Throughput: one item at a time; busy drops as the strobe rises, so the next
//   item is taken at the edge that ends the strobe cycle.
// Reset: synchronous active-low; sequencer idles, clamp limit returns to 4.18.
module clamped_float_power
    import cfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_base_bits,
    input  logic [31:0] i_power,
    input  logic        i_is_last_in,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_clamp_limit,
    output logic        o_valid,
    output logic [31:0] o_result_bits,
    output logic        o_is_last_out
);

    t_state      r_state, n_state;
    logic [31:0] r_limit;
    logic [31:0] r_acc, r_sq, r_y;
    logic        r_last;
    logic        r_sel_acc;   // current multiply: 1 = acc*sq, 0 = sq*sq
    t_prod       r_prod;
    logic        r_valid;
    logic [31:0] r_res;
    logic [31:0] v_ma, v_mb, v_rnd;
    t_unp        v_ua, v_ub;

    assign o_cfg_ready   = 1'b1;
    assign busy          = (r_state != ST_IDLE);
    assign o_valid       = r_valid;
    assign o_result_bits = r_res;
    assign o_is_last_out = r_last;

    always_comb begin
        v_ma = r_sel_acc ? r_acc : r_sq;
        v_mb = r_sq;
        v_ua = unpack(v_ma);
        v_ub = unpack(v_mb);
        v_rnd = round_pack(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_clamp_limit;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (start) n_state = (i_power[31] || i_power == 32'd0) ? ST_DONE : ST_MUL;
            ST_MUL:  n_state = ST_NORM;
            ST_NORM: n_state = ST_MUL;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
        if (r_state == ST_NORM) begin
            // result multiply: stop on a clamp or after the top set bit
            if (r_sel_acc && (fgt(v_rnd, r_limit) || r_y[31:1] == 31'd0)) n_state = ST_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_acc     <= ONE_BITS;
                r_sq      <= i_base_bits;
                r_y       <= i_power;
                r_last    <= i_is_last_in;
                r_sel_acc <= i_power[0];
            end
            ST_MUL: begin
                r_prod.sgn  <= v_ua.sgn ^ v_ub.sgn;
                r_prod.exp  <= v_ua.exp + v_ub.exp;
                r_prod.prod <= v_ua.man * v_ub.man;
                r_prod.nan  <= v_ua.nan | v_ub.nan;
                r_prod.inf  <= v_ua.inf | v_ub.inf;
                r_prod.zero <= v_ua.zero | v_ub.zero;
            end
            ST_NORM: begin
                if (r_sel_acc) begin
                    r_acc     <= fgt(v_rnd, r_limit) ? r_limit : v_rnd;
                    r_sel_acc <= 1'b0;
                    // no squaring needed after the top set bit
                    if (r_y[31:1] == 31'd0) r_y <= 32'd0;
                end else begin
                    r_sq      <= v_rnd;
                    r_y       <= r_y >> 1;
                    r_sel_acc <= r_y[1];
                end
            end
            ST_DONE: begin
                if (r_y[31]) begin
                    r_res <= ONE_BITS;
                end else if (r_y == 32'd0 && r_acc[30:23] == 8'hFF && r_acc[22:0] != 23'd0) begin
                    r_res <= QNAN_BITS;
                end else begin
                    r_res <= r_acc;
                end
            end
            default: ;
        endcase
    end

endmodule

/* design/cfp_checker.sv */
// ----------------------------------------------------------------------------
// cfp_checker: port-level checks for clamped_float_power
// Watches the command handshake and the result strobe.
// ----------------------------------------------------------------------------
module cfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [31:0] i_power,
    input logic        o_valid,
    input logic [31:0] o_result_bits
);

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("busy not raised");

    a_nonpos_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_power[31] || i_power == 32'd0)) |-> ##2
        (o_valid && o_result_bits == 32'h3F80_0000)) else $error("non-positive power");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("strobe longer than one cycle");

    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");

endmodule

bind clamped_float_power cfp_checker u_cfp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .i_power(i_power), .o_valid(o_valid), .o_result_bits(o_result_bits)
);

/* tb/clamped_float_power_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clamped_float_power_test: self-checking bench for the saturating float power
// Drives a short table of corner items and then random items under several
// clamp limits. Each result is checked against a bit-level float32 power model
// kept in the bench or against a pinned table value, with random command gaps.
// ----------------------------------------------------------------------------
module clamped_float_power_test
    import cfp_pkg::*;
();

    typedef struct {
        logic [31:0] base;
        logic [31:0] pwr;
        logic        last;
        logic        pinned;
        logic [31:0] pin_bits;
    } t_row;

    typedef struct {
        logic [31:0] bits;
        logic        last;
    } t_power_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_base_bits = '0;
    logic [31:0] i_power = '0;
    logic        i_is_last_in = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_clamp_limit = '0;
    logic        o_valid;
    logic [31:0] o_result_bits;
    logic        o_is_last_out;

    logic [31:0] limit_bits = LIMIT_RESET;
    logic        pin_now = 1'b0;
    logic [31:0] pin_val = '0;
    t_power_res  pending_q[$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          clamps_seen = 0;
    int          cycles = 0;
    bit          idle_on = 1'b1;

    localparam int CYCLE_LIMIT = 600000;

    clamped_float_power dut (.*);

    always #5 i_clk = ~i_clk;

    // ---------------- float32 model ----------------
    function automatic logic is_nan32(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 0);
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic              sgn;
        int                ea, eb, ex, lead, sh;
        longint unsigned   p, kept, rem, half;
        logic              a_inf, b_inf, a_zero, b_zero;
        sgn    = a[31] ^ b[31];
        a_inf  = a[30:0] == 31'h7F80_0000;
        b_inf  = b[30:0] == 31'h7F80_0000;
        a_zero = a[30:0] == 0;
        b_zero = b[30:0] == 0;
        if (is_nan32(a) || is_nan32(b) || (a_inf && b_zero) || (b_inf && a_zero))
            return QNAN_BITS;
        if (a_inf || b_inf) return {sgn, 31'h7F80_0000};
        if (a_zero || b_zero) return {sgn, 31'd0};
        ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
        eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
        p  = longint'({(a[30:23] != 0), a[22:0]}) * longint'({(b[30:23] != 0), b[22:0]});
        lead = 0;
        for (int i = 0; i < 48; i++) if (p[i]) lead = i;
        // value = p * 2^(ea+eb-254-46); target 24-bit significand at biased ex
        ex = ea + eb - 127 + (lead - 46);
        sh = lead - 23;
        if (ex < 1) begin
            sh = sh + (1 - ex);
            ex = 0;
        end
        if (sh <= 0) begin
            kept = p << (-sh);
        end else begin
            if (sh > 60) sh = 60;
            kept = p >> sh;
            rem  = p & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && kept[0])) kept = kept + 1;
        end
        if (kept[24]) begin
            kept = kept >> 1;
            ex = ex + 1;
        end
        if (ex == 0 && kept[23]) ex = 1;
        if (ex >= 255) return {sgn, 31'h7F80_0000};
        return {sgn, 8'(ex), kept[22:0]};
    endfunction

    function automatic logic fp_greater(input logic [31:0] a, input logic [31:0] b);
        if (is_nan32(a) || is_nan32(b)) return 1'b0;
        if (a[30:0] == 0 && b[30:0] == 0) return 1'b0;
        if (a[31] != b[31]) return !a[31];
        if (!a[31]) return a[30:0] > b[30:0];
        return a[30:0] < b[30:0];
    endfunction

    function automatic logic [31:0] clamped_pow(input logic [31:0] base, input logic [31:0] pwr,
                                                input logic [31:0] lim);
        logic [31:0] acc, sq, y;
        acc = ONE_BITS;
        sq  = base;
        y   = pwr;
        if (pwr[31] || pwr == 0) return ONE_BITS;
        while (y != 0) begin
            if (y[0]) begin
                acc = fp_mul(acc, sq);
                if (fp_greater(acc, lim)) return lim;
            end
            sq = fp_mul(sq, sq);
            y  = y >> 1;
        end
        return is_nan32(acc) ? QNAN_BITS : acc;
    endfunction

    // ---------------- checking ----------------
    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
    endtask

    always @(posedge i_clk) begin
        t_power_res r;
        cycles <= cycles + 1;
        if (i_rst_n && start && !busy) begin
            r.bits = pin_now ? pin_val : clamped_pow(i_base_bits, i_power, limit_bits);
            r.last = i_is_last_in;
            pending_q.push_back(r);
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) limit_bits <= i_cfg_clamp_limit;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (pending_q.size() == 0) begin
                report("unexpected beat", o_result_bits, 32'h0);
            end else begin
                r = pending_q.pop_front();
                if (o_result_bits !== r.bits) report("result_bits", o_result_bits, r.bits);
                if (o_is_last_out !== r.last)
                    report("is_last_out", {31'd0, o_is_last_out}, {31'd0, r.last});
                if (o_result_bits === limit_bits && r.bits === limit_bits) clamps_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[clamped_float_power] ERROR");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic [31:0] rand_base();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0, 1, 2, 3: return {1'($urandom), 8'($urandom_range(124, 128)), 23'($urandom)};
            4:          return {1'($urandom), 8'd0, 23'($urandom)};
            5:          return {1'($urandom), 8'hFF, 23'($urandom_range(0, 1) ? 0 : $urandom)};
            6:          return {1'($urandom), 8'($urandom_range(1, 40)), 23'($urandom)};
            7:          return {1'($urandom), 31'd0};
            default:    return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_power();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6) return $urandom_range(1, 40);
        if (k == 6) return -$urandom_range(0, 5);
        if (k == 7) return $urandom_range(41, 4096);
        return $urandom;
    endfunction

    task automatic send(input t_row row);
        if (idle_on) begin
            while ($urandom_range(0, 99) < 30) @(negedge i_clk);
        end
        start        = 1'b1;
        i_base_bits  = row.base;
        i_power      = row.pwr;
        i_is_last_in = row.last;
        pin_now      = row.pinned;
        pin_val      = row.pin_bits;
        #1;
        while (busy) begin
            @(negedge i_clk);
            #1;
        end
        @(negedge i_clk);
        start   = 1'b0;
        pin_now = 1'b0;
        items_sent++;
    endtask

    task automatic drain();
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        i_cfg_valid       = 1'b1;
        i_cfg_clamp_limit = v;
        #1;
        while (!o_cfg_ready) begin
            @(negedge i_clk);
            #1;
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    t_row directed[] = '{
        '{32'h4000_0000, 32'd0,          1'b0, 1'b1, ONE_BITS},
        '{32'h7FC1_2345, 32'h8000_0000, 1'b1, 1'b1, ONE_BITS},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, ONE_BITS},
        '{32'h7F80_0000, 32'd1,          1'b1, 1'b1, LIMIT_RESET},
        '{32'h7F80_0001, 32'd3,          1'b0, 1'b1, QNAN_BITS},
        '{32'h4000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1, LIMIT_RESET},
        '{32'h4000_0000, 32'd1,          1'b0, 1'b0, 32'h0},
        '{32'h4000_0000, 32'd2,          1'b0, 1'b0, 32'h0},
        '{32'h4000_0000, 32'd3,          1'b1, 1'b0, 32'h0},
        '{32'hBF80_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0001, 32'd1,          1'b1, 1'b0, 32'h0},
        '{32'h0000_0001, 32'd2,          1'b0, 1'b0, 32'h0},
        '{32'h007F_FFFF, 32'd2,          1'b0, 1'b0, 32'h0},
        '{32'h1F80_0000, 32'd5,          1'b1, 1'b0, 32'h0},
        '{32'h8000_0000, 32'd7,          1'b0, 1'b0, 32'h0},
        '{32'hFF80_0000, 32'd2,          1'b0, 1'b0, 32'h0},
        '{32'h0000_0000, 32'd0,          1'b1, 1'b0, 32'h0},
        '{32'h3F7F_FFFF, 32'h4000_0000, 1'b0, 1'b0, 32'h0},
        '{32'h3F80_0001, 32'd37,         1'b1, 1'b0, 32'h0},
        '{32'hC000_0000, 32'd2,          1'b0, 1'b0, 32'h0}
    };

    logic [31:0] limits[] = '{32'hFFFF_FFFF, 32'h7F80_0000, 32'h0000_0000, 32'hFF80_0000,
                              32'h7F7F_FFFF, 32'h3F80_0000, 32'h4120_0000, LIMIT_RESET};

    initial begin
        t_row row;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (directed[i]) send(directed[i]);
        foreach (limits[p]) begin
            // pause until the block is empty before each register write
            drain();
            write_limit(p == 6 ? $urandom : limits[p]);
            idle_on = (p != 1);
            repeat (80) begin
                row.base   = rand_base();
                row.pwr    = rand_power();
                row.last   = 1'($urandom);
                row.pinned = 1'b0;
                send(row);
            end
        end
        drain();
        $display("covered %0d items, %0d results, %0d clamped, %0d limit settings",
                 items_sent, results_seen, clamps_seen, limits.size() + 1);
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("[clamped_float_power] OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_q.size());
            $display("[clamped_float_power] ERROR");
        end
        $finish;
    end

endmodule
